FILE: rtl/vli_pkg.sv
`timescale 1ns / 1ps
package vli_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SMP_W     = 16;
	localparam int ADV_W     = 28;
	localparam int IDX_W     = 16;
	localparam int PH_W      = 33;
	localparam int POS_W     = 34;
	localparam int LEN_W     = 17;
	localparam int BLK_W     = 7;
	localparam int CFG_W     = 2;
	localparam int DIV_W     = 34;
	localparam int DVS_W     = 33;
	localparam int DIV_CNT_W = 6;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [CFG_W-1:0] CFG_LOOP  = 2'd0;
	localparam logic [CFG_W-1:0] CFG_LEN   = 2'd1;
	localparam logic [CFG_W-1:0] CFG_BLOCK = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_WRAP,
		ST_FIX,
		ST_SPAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic            zero;
		logic            last;
		logic [PH_W-1:0] pos;
	} issue_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: rtl/vli_div.sv
`timescale 1ns / 1ps
module vli_div (
	input  logic               clk,
	input  logic               arst_n,
	input  vli_pkg::div_req_t  req,
	output vli_pkg::div_rsp_t  rsp
);

	localparam int DIV_W = vli_pkg::DIV_W;
	localparam int DVS_W = vli_pkg::DVS_W;
	localparam int CNT_W = vli_pkg::DIV_CNT_W;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0] sh_w;
	logic [DVS_W:0] diff_w;
	logic           fits_w;

	assign sh_w   = {rem_q, quo_q[DIV_W-1]};
	assign fits_w = sh_w >= {1'b0, dvs_q};
	assign diff_w = sh_w - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits_w};
			rem_q <= fits_w ? diff_w[DVS_W-1:0] : sh_w[DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/vli_voice.sv
`timescale 1ns / 1ps
module vli_voice #(
	parameter int STORE_DEPTH = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [$clog2(STORE_DEPTH)-1:0]       wr_addr,
	input  logic signed [vli_pkg::SMP_W-1:0]     wr_data,
	input  logic                                 iss_valid,
	input  vli_pkg::issue_t                      iss,
	output logic                                 iss_ready,
	output logic                                 busy,
	input  logic [vli_pkg::PH_W-1:0]             playhead,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [vli_pkg::SMP_W-1:0]     sample,
	output logic                                 last_of_block,
	output logic [vli_pkg::PH_W-1:0]             playhead_pos
);

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int SMP_W = vli_pkg::SMP_W;
	localparam int FB    = vli_pkg::FRAC_BITS;
	localparam int PRD_W = SMP_W + FB + 2;

	logic signed [SMP_W-1:0] store_q [STORE_DEPTH];

	logic adv;
	logic v_s1, v_s2, v_s3, res_valid_q;

	logic [AW-1:0]            addr_s1;
	logic [FB-1:0]            frac_s1, frac_s2;
	logic                     zero_s1, zero_s2, zero_s3;
	logic                     last_s1, last_s2, last_s3;
	logic signed [SMP_W-1:0]  a_s2, b_s2, a_s3;
	logic signed [PRD_W-1:0]  prod_s3;
	logic signed [SMP_W:0]    diff_w;
	logic signed [SMP_W-1:0]  sample_q;
	logic                     last_q;
	logic [vli_pkg::PH_W-1:0] ph_q;

	assign adv       = !res_valid_q || !res_stall;
	assign iss_ready = adv;
	assign busy      = v_s1 || v_s2 || v_s3;
	assign diff_w    = {b_s2[SMP_W-1], b_s2} - {a_s2[SMP_W-1], a_s2};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= iss_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1  <= AW'(iss.pos >> FB);
			frac_s1  <= iss.pos[FB-1:0];
			zero_s1  <= iss.zero;
			last_s1  <= iss.last;
			a_s2     <= store_q[addr_s1];
			b_s2     <= store_q[addr_s1 + AW'(1)];
			frac_s2  <= frac_s1;
			zero_s2  <= zero_s1;
			last_s2  <= last_s1;
			prod_s3  <= diff_w * $signed({1'b0, frac_s2});
			a_s3     <= a_s2;
			zero_s3  <= zero_s2;
			last_s3  <= last_s2;
			sample_q <= zero_s3 ? '0 : SMP_W'(a_s3 + (prod_s3 >>> FB));
			last_q   <= last_s3;
			ph_q     <= playhead;
		end
	end

	assign res_valid     = res_valid_q;
	assign sample        = sample_q;
	assign last_of_block = last_q;
	assign playhead_pos  = ph_q;

endmodule

FILE: rtl/varispeed_linear_interp_player.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// item      item_valid/item_stall   cmd, load_index, load_value, advance, play
// result    result_valid/result_stall  sample, last_of_block, playhead_pos
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A load word is written to the store when taken. A tick word is entered, its new
// playhead is evaluated, the divider wraps it when it leaves a looped clip, the playhead
// settles, the divider forms the step size when the block is not silent, then one output
// word per cycle goes to store read and interpolation while the result side takes them.
// The next item is taken only after the interpolation pipeline has drained.
// Reset clears control state, settings and playhead; the sample store is not cleared.
module varispeed_linear_interp_player #(
	parameter int STORE_DEPTH = 65536,
	parameter int MAX_BLOCK   = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 cmd,
	input  logic [vli_pkg::IDX_W-1:0]            load_index,
	input  logic signed [vli_pkg::SMP_W-1:0]     load_value,
	input  logic signed [vli_pkg::ADV_W-1:0]     advance,
	input  logic                                 play,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [vli_pkg::SMP_W-1:0]     sample,
	output logic                                 last_of_block,
	output logic [vli_pkg::PH_W-1:0]             playhead_pos,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vli_pkg::CFG_W-1:0]            cfg_index,
	input  logic [vli_pkg::LEN_W-1:0]            cfg_data
);

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int VCW   = $clog2(STORE_DEPTH + 1);
	localparam int NW    = $clog2(MAX_BLOCK + 1);
	localparam int PH_W  = vli_pkg::PH_W;
	localparam int POS_W = vli_pkg::POS_W;
	localparam int LEN_W = vli_pkg::LEN_W;
	localparam int BLK_W = vli_pkg::BLK_W;
	localparam int FB    = vli_pkg::FRAC_BITS;

	vli_pkg::state_t state_q, state_d;

	logic             loop_q;
	logic [LEN_W-1:0] clip_q;
	logic [BLK_W-1:0] blk_q;
	logic [PH_W-1:0]  playhead_q;
	logic [VCW-1:0]   vc_q;

	logic signed [POS_W-1:0] t1raw_q;
	logic                    play_q;
	logic [PH_W-1:0]         t0_q, t1_q;
	logic                    wrapped_q, silent_q, dir_neg_q;
	logic [NW-1:0]           n_q, r0_q, r_q, j_q;
	logic [PH_W-1:0]         q0_q, q_q;

	logic                    item_take, load_take, in_store_w;
	logic [31:0]             idx1_w;
	logic [LEN_W-1:0]        clip_eff_w;
	logic [PH_W-1:0]         len_w;
	logic signed [POS_W-1:0] len_s_w, step_w, t1raw_w;
	logic                    neg_w, oor_w;
	logic [vli_pkg::DIV_W-1:0] mag_raw_w;
	logic [PH_W-1:0]         clamp_w, wrap_w, span_mag_w, pos_w;
	logic                    dir_w, silent_w, zero_w, last_w, rwrap_w;
	logic [NW-1:0]           n_w;
	logic [NW:0]             rsum_w;

	vli_pkg::div_req_t div_req;
	vli_pkg::div_rsp_t div_rsp;
	vli_pkg::issue_t   iss;
	logic              iss_valid, iss_ready, pipe_busy;

	assign item_stall = !(state_q == vli_pkg::ST_IDLE && !pipe_busy);
	assign item_take  = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign idx1_w     = 32'(load_index) + 32'd1;
	assign in_store_w = 32'(load_index) < 32'(STORE_DEPTH);
	assign load_take  = item_take && cmd == vli_pkg::CMD_LOAD && in_store_w;

	assign clip_eff_w = (clip_q == '0) ? LEN_W'(1) : clip_q;
	assign len_w      = {clip_eff_w, {FB{1'b0}}};
	assign len_s_w    = $signed({1'b0, len_w});
	assign step_w     = play ? POS_W'(advance) : '0;
	assign t1raw_w    = $signed({1'b0, playhead_q}) + step_w;

	assign neg_w     = t1raw_q[POS_W-1];
	assign oor_w     = neg_w || (t1raw_q >= len_s_w);
	assign mag_raw_w = vli_pkg::DIV_W'(neg_w ? -t1raw_q : t1raw_q);

	always_comb begin
		if (neg_w) begin
			clamp_w = '0;
		end else if (t1raw_q > len_s_w) begin
			clamp_w = len_w;
		end else begin
			clamp_w = t1raw_q[PH_W-1:0];
		end
	end

	assign wrap_w     = (neg_w && div_rsp.rem != '0) ? len_w - div_rsp.rem : div_rsp.rem;
	assign dir_w      = t1_q < playhead_q;
	assign span_mag_w = dir_w ? playhead_q - t1_q : t1_q - playhead_q;
	assign silent_w   = !play_q || wrapped_q || vc_q < VCW'(2) || t1_q == playhead_q;

	always_comb begin
		if (blk_q == '0) begin
			n_w = NW'(1);
		end else if (32'(blk_q) > 32'(MAX_BLOCK)) begin
			n_w = NW'(MAX_BLOCK);
		end else begin
			n_w = NW'(blk_q);
		end
	end

	assign pos_w   = dir_neg_q ? t0_q - q_q : t0_q + q_q;
	assign zero_w  = silent_q || (64'(pos_w) >= ((64'(vc_q) - 64'd1) << FB));
	assign last_w  = j_q == n_q - NW'(1);
	assign rsum_w  = {1'b0, r_q} + {1'b0, r0_q};
	assign rwrap_w = rsum_w >= {1'b0, n_q};

	assign iss_valid = state_q == vli_pkg::ST_EMIT;
	assign iss.zero  = zero_w;
	assign iss.last  = last_w;
	assign iss.pos   = pos_w;

	always_comb begin
		state_d = state_q;
		div_req = '0;
		unique case (state_q)
			vli_pkg::ST_IDLE: begin
				if (item_take && cmd == vli_pkg::CMD_TICK) begin
					state_d = vli_pkg::ST_PREP;
				end
			end
			vli_pkg::ST_PREP: begin
				if (loop_q && oor_w) begin
					div_req.start    = 1'b1;
					div_req.dividend = mag_raw_w;
					div_req.divisor  = len_w;
					state_d          = vli_pkg::ST_WRAP;
				end else begin
					state_d = vli_pkg::ST_FIX;
				end
			end
			vli_pkg::ST_WRAP: begin
				if (div_rsp.done) begin
					state_d = vli_pkg::ST_FIX;
				end
			end
			vli_pkg::ST_FIX: begin
				if (silent_w) begin
					state_d = vli_pkg::ST_EMIT;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {1'b0, span_mag_w};
					div_req.divisor  = vli_pkg::DVS_W'(n_w);
					state_d          = vli_pkg::ST_SPAN;
				end
			end
			vli_pkg::ST_SPAN: begin
				if (div_rsp.done) begin
					state_d = vli_pkg::ST_EMIT;
				end
			end
			vli_pkg::ST_EMIT: begin
				if (iss_ready && last_w) begin
					state_d = vli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vli_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vli_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q     <= 1'b1;
			clip_q     <= LEN_W'(65536);
			blk_q      <= BLK_W'(64);
			playhead_q <= '0;
			vc_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					vli_pkg::CFG_LOOP:  loop_q <= cfg_data[0];
					vli_pkg::CFG_LEN:   clip_q <= cfg_data;
					vli_pkg::CFG_BLOCK: blk_q  <= cfg_data[BLK_W-1:0];
					default: begin
					end
				endcase
			end
			if (load_take && idx1_w > 32'(vc_q)) begin
				vc_q <= VCW'(idx1_w);
			end
			if (state_q == vli_pkg::ST_FIX) begin
				playhead_q <= t1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vli_pkg::ST_IDLE: begin
				if (item_take) begin
					t1raw_q <= t1raw_w;
					play_q  <= play;
				end
			end
			vli_pkg::ST_PREP: begin
				wrapped_q <= loop_q && oor_w;
				t1_q      <= loop_q ? t1raw_q[PH_W-1:0] : clamp_w;
			end
			vli_pkg::ST_WRAP: begin
				if (div_rsp.done) begin
					t1_q <= wrap_w;
				end
			end
			vli_pkg::ST_FIX: begin
				t0_q      <= playhead_q;
				dir_neg_q <= dir_w;
				silent_q  <= silent_w;
				n_q       <= n_w;
				q0_q      <= '0;
				r0_q      <= '0;
				q_q       <= '0;
				r_q       <= '0;
				j_q       <= '0;
			end
			vli_pkg::ST_SPAN: begin
				if (div_rsp.done) begin
					q0_q <= div_rsp.quot[PH_W-1:0];
					r0_q <= NW'(div_rsp.rem);
				end
			end
			vli_pkg::ST_EMIT: begin
				if (iss_ready) begin
					j_q <= j_q + NW'(1);
					if (rwrap_w) begin
						r_q <= NW'(rsum_w - {1'b0, n_q});
						q_q <= q_q + q0_q + PH_W'(1);
					end else begin
						r_q <= NW'(rsum_w);
						q_q <= q_q + q0_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	vli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	vli_voice #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_voice (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (load_take),
		.wr_addr       (AW'(load_index)),
		.wr_data       (load_value),
		.iss_valid     (iss_valid),
		.iss           (iss),
		.iss_ready     (iss_ready),
		.busy          (pipe_busy),
		.playhead      (playhead_q),
		.res_valid     (result_valid),
		.res_stall     (result_stall),
		.sample        (sample),
		.last_of_block (last_of_block),
		.playhead_pos  (playhead_pos)
	);

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == vli_pkg::ST_WRAP || state_q == vli_pkg::ST_SPAN))
		else $error("divider finished outside a wait state");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vli_pkg::ST_EMIT |-> j_q < n_q)
		else $error("block word count ran past the block length");

	a_step_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vli_pkg::ST_EMIT |-> r_q < n_q)
		else $error("position step remainder out of range");

endmodule

FILE: bench/tb_varispeed_linear_interp_player.sv
`timescale 1ns / 1ps
module tb_varispeed_linear_interp_player;
	import vli_pkg::*;

	localparam int MAX_BLOCK_WORDS = 64;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int DRAIN_CYCLES    = 120;
	localparam int PHASE_ITEMS     = 53;
	localparam logic [CFG_W-1:0] CFG_SPARE = 2'd3;

	localparam int MODE_STEADY    = 0;
	localparam int MODE_SEND_IDLE = 1;
	localparam int MODE_RECV_STALL = 2;
	localparam int MODE_BOTH      = 3;

	typedef struct {
		logic signed [SMP_W-1:0] value;
		logic                    last;
		logic [PH_W-1:0]         pos;
	} out_word_t;

	typedef struct {
		logic                    op;
		logic [IDX_W-1:0]        index;
		logic signed [SMP_W-1:0] value;
		logic signed [ADV_W-1:0] step;
		logic                    run;
	} in_word_t;

	class playback_checker;
		bit                    loop_on;
		bit [LEN_W-1:0]        clip_len;
		bit [BLK_W-1:0]        blk_len;
		longint                head;
		int                    valid_cnt;
		bit signed [SMP_W-1:0] pcm [0:65535];
		out_word_t             due_words [$];
		int                    errors;

		function new();
			loop_on = 1'b1;
			clip_len = 17'h10000;
			blk_len = 7'd64;
			head = 0;
			valid_cnt = 0;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(logic [CFG_W-1:0] idx, logic [LEN_W-1:0] data);
			case (idx)
				CFG_LOOP: loop_on = data[0];
				CFG_LEN: clip_len = data;
				CFG_BLOCK: blk_len = data[BLK_W-1:0];
				default: ;
			endcase
		endfunction

		function bit signed [SMP_W-1:0] interp_at(longint pos);
			longint one, i, fr, a, b, acc;
			one = longint'(1) << FRAC_BITS;
			if (valid_cnt < 2 || pos < 0)
				return '0;
			if (pos >= longint'(valid_cnt - 1) * one)
				return '0;
			i = pos / one;
			fr = pos - i * one;
			a = longint'(pcm[i]);
			b = longint'(pcm[i + 1]);
			acc = a * (one - fr) + b * fr + 32768 * one;
			return SMP_W'(acc / one - 32768);
		endfunction

		function void take_item(in_word_t w);
			longint t0, t1, len, span, one;
			int n, j;
			bit wrapped, silent;
			out_word_t o;
			one = longint'(1) << FRAC_BITS;
			if (w.op == CMD_LOAD) begin
				pcm[w.index] = w.value;
				if (int'(w.index) + 1 > valid_cnt)
					valid_cnt = int'(w.index) + 1;
				return;
			end
			t0 = head;
			t1 = t0;
			if (w.run)
				t1 = t1 + longint'(w.step);
			len = (clip_len == 0) ? one : longint'(clip_len) * one;
			wrapped = 1'b0;
			if (loop_on) begin
				if (t1 >= len || t1 < 0) begin
					t1 = t1 % len;
					if (t1 < 0)
						t1 = t1 + len;
					wrapped = 1'b1;
				end
			end else begin
				if (t1 < 0)
					t1 = 0;
				if (t1 > len)
					t1 = len;
			end
			head = t1;
			n = int'(blk_len);
			if (n < 1)
				n = 1;
			if (n > MAX_BLOCK_WORDS)
				n = MAX_BLOCK_WORDS;
			silent = !w.run || wrapped || valid_cnt < 2 || t0 == t1;
			span = t1 - t0;
			for (j = 0; j < n; j++) begin
				o.value = silent ? '0 : interp_at(t0 + (span * longint'(j)) / longint'(n));
				o.last = (j == n - 1);
				o.pos = t1[PH_W-1:0];
				due_words.push_back(o);
			end
		endfunction

		task check_word(logic signed [SMP_W-1:0] value, logic last, logic [PH_W-1:0] pos);
			out_word_t w;
			if (due_words.size() == 0) begin
				report($sformatf("word with nothing due: sample %0d last %b", value, last));
				return;
			end
			w = due_words.pop_front();
			if (value !== w.value)
				report($sformatf("sample got %0d want %0d", value, w.value));
			if (last !== w.last)
				report($sformatf("last_of_block got %b want %b", last, w.last));
			if (pos !== w.pos)
				report($sformatf("playhead_pos got 0x%0h want 0x%0h", pos, w.pos));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_stall;
	logic                    cmd;
	logic [IDX_W-1:0]        load_index;
	logic signed [SMP_W-1:0] load_value;
	logic signed [ADV_W-1:0] advance;
	logic                    play;
	logic                    result_valid;
	logic                    result_stall;
	logic signed [SMP_W-1:0] sample;
	logic                    last_of_block;
	logic [PH_W-1:0]         playhead_pos;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_index;
	logic [LEN_W-1:0]        cfg_data;

	playback_checker sb;
	int send_pct = 0;
	int recv_pct = 0;
	int prefix_len = 0;
	int cycles = 0;

	varispeed_linear_interp_player uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cmd(cmd),
		.load_index(load_index),
		.load_value(load_value),
		.advance(advance),
		.play(play),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sample(sample),
		.last_of_block(last_of_block),
		.playhead_pos(playhead_pos),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && result_valid && !result_stall)
			sb.check_word(sample, last_of_block, playhead_pos);
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic set_mode(input int mode);
		case (mode)
			MODE_SEND_IDLE: begin
				send_pct = 78;
				recv_pct = 0;
			end
			MODE_RECV_STALL: begin
				send_pct = 0;
				recv_pct = 78;
			end
			MODE_BOTH: begin
				send_pct = 8;
				recv_pct = 8;
			end
			default: begin
				send_pct = 0;
				recv_pct = 0;
			end
		endcase
	endtask

	task automatic send_item(input in_word_t it);
		int gap;
		gap = 0;
		while (gap < 64 && $urandom_range(99) < send_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		cmd <= it.op;
		load_index <= it.index;
		load_value <= it.value;
		advance <= it.step;
		play <= it.run;
		do @(posedge clk); while (item_stall);
		sb.take_item(it);
	endtask

	task automatic load(input int idx, input int val);
		in_word_t it;
		it.op = CMD_LOAD;
		it.index = IDX_W'(idx);
		it.value = SMP_W'(val);
		it.step = '0;
		it.run = 1'b0;
		send_item(it);
	endtask

	task automatic tick(input int step, input bit run);
		in_word_t it;
		it.op = CMD_TICK;
		it.index = '0;
		it.value = '0;
		it.step = ADV_W'(step);
		it.run = run;
		send_item(it);
	endtask

	task automatic write_reg(input logic [CFG_W-1:0] idx, input int unsigned data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= LEN_W'(data);
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, LEN_W'(data));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_word_t random_item(input bit high_loads);
		in_word_t it;
		int r;
		it.op = ($urandom_range(99) < 40) ? CMD_LOAD : CMD_TICK;
		it.index = IDX_W'($urandom);
		it.value = SMP_W'($urandom);
		it.step = ADV_W'($urandom);
		it.run = ($urandom_range(99) < 88);
		if (it.op == CMD_LOAD) begin
			if (high_loads) begin
				if ($urandom_range(1) == 0)
					it.index[IDX_W-1] = 1'b1;
				else
					it.index = IDX_W'($urandom_range(prefix_len - 1));
			end else if ($urandom_range(1) == 0) begin
				it.index = IDX_W'(sb.valid_cnt);
			end else begin
				it.index = IDX_W'($urandom_range(sb.valid_cnt));
			end
		end else begin
			r = $urandom_range(99);
			if (r < 5)
				it.step = '0;
			else if (r < 60)
				it.step = ADV_W'($urandom_range(8 << FRAC_BITS));
			else if (r < 75)
				it.step = ADV_W'(-int'($urandom_range(8 << FRAC_BITS)));
			else if (r < 90)
				it.step = ADV_W'(int'($urandom_range(128 << FRAC_BITS)) - (64 << FRAC_BITS));
		end
		return it;
	endfunction

	task automatic run_phase(input int mode, input bit loop_v, input int unsigned clip_v,
		input int unsigned blk_v, input bit high_loads);
		write_reg(CFG_LOOP, loop_v);
		write_reg(CFG_LEN, clip_v);
		write_reg(CFG_BLOCK, blk_v);
		set_mode(mode);
		repeat (PHASE_ITEMS) send_item(random_item(high_loads));
		settle();
	endtask

	initial begin
		int clip_v;
		arst_n = 1'b0;
		item_valid = 1'b0;
		cmd = CMD_LOAD;
		load_index = '0;
		load_value = '0;
		advance = '0;
		play = 1'b0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LOOP;
		cfg_data = '0;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: looping over the full store length, 64 words per tick.
		set_mode(MODE_STEADY);
		tick(1 << FRAC_BITS, 1'b1);
		load(0, -32768);
		tick(1 << FRAC_BITS, 1'b1);
		load(1, 32767);
		load(2, 0);
		load(3, -1);
		load(4, 16'sh1234);
		load(5, -20000);
		load(6, 32767);
		load(7, -32768);
		load(2, 555);
		tick(-(2 << FRAC_BITS) + 16'h8000, 1'b1);
		tick((5 << FRAC_BITS) + 16'h1234, 1'b1);
		tick(3 << FRAC_BITS, 1'b0);
		tick(0, 1'b1);
		tick(134217727, 1'b1);
		tick(-134217728, 1'b1);
		tick(-134217728, 1'b1);
		tick(8 << FRAC_BITS, 1'b1);
		tick(1 << FRAC_BITS, 1'b0);
		settle();

		run_phase(MODE_STEADY, 1'b1, 200, 16, 1'b0);
		run_phase(MODE_SEND_IDLE, 1'b0, 150, 64, 1'b0);
		run_phase(MODE_RECV_STALL, 1'b1, 1, 1, 1'b0);
		run_phase(MODE_BOTH, 1'b0, 65536, 0, 1'b0);
		write_reg(CFG_SPARE, $urandom);
		run_phase(MODE_STEADY, 1'b1, 0, 127, 1'b0);
		run_phase(MODE_RECV_STALL, 1'b0, 131071, 33, 1'b0);
		run_phase(MODE_SEND_IDLE, 1'b1, 300, $urandom_range(64, 1), 1'b0);
		run_phase(MODE_BOTH, 1'b0, $urandom_range(400, 1), $urandom_range(64, 1), 1'b0);

		// High store addresses from here on; the short loop keeps every read
		// inside the contiguous written prefix.
		prefix_len = sb.valid_cnt;
		clip_v = prefix_len - 2;
		if (clip_v > 120)
			clip_v = 120;
		if (clip_v < 1)
			clip_v = 1;
		run_phase(MODE_STEADY, 1'b1, clip_v, $urandom_range(64, 1), 1'b1);

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
